### rtl/core/edd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the error diffusion dither block.
// No dependencies; every other file of the block refers to this package by scoped names.

package edd_pkg;

   localparam int WIDTH_MAX = 1024;
   localparam int COL_W     = $clog2(WIDTH_MAX);
   localparam int CNT_W     = COL_W + 1;

   localparam int CHAN_W    = 8;
   localparam int LUMA_W    = 16;
   localparam int ERR_W     = 20;
   localparam int WIDE_W    = 24;

   localparam int CSR_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int WIDTH_REG_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd2;

   localparam logic [CHAN_W-1:0]      THRESHOLD_RESET = 8'd128;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET     = 11'd1024;

   localparam logic MODE_FLOYD    = 1'b0;
   localparam logic MODE_ATKINSON = 1'b1;

   localparam int COEF_R = 77;
   localparam int COEF_G = 150;
   localparam int COEF_B = 29;

   localparam int FULL_Q88 = 255 * 256;
   localparam int W_RIGHT  = 7;
   localparam int W_LEFT   = 3;
   localparam int W_MID    = 5;
   localparam int SHIFT_FS = 4;
   localparam int SHIFT_AT = 3;

   localparam int ERR_MAX = (2 ** (ERR_W - 1)) - 1;
   localparam int ERR_MIN = -(2 ** (ERR_W - 1));

   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   typedef logic [COL_W-1:0]         col_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [LUMA_W-1:0]        luma_type;
   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      col_type           col;
      logic              last;
      logic              frame_start;
      luma_type          luma;
      logic [CHAN_W-1:0] alpha;
   } pix_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic s1_valid;
      logic out_valid;
   } bstat_type;

   function automatic err_type sat_err(input wide_type v);
      err_type r;
      if (v > wide_type'(ERR_MAX)) begin
         r = err_type'(ERR_MAX);
      end else if (v < wide_type'(ERR_MIN)) begin
         r = err_type'(ERR_MIN);
      end else begin
         r = err_type'(v);
      end
      return r;
   endfunction

endpackage

### rtl/core/edd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests and dithered responses.
// Depends on edd_pkg for field widths.

interface edd_req_if;
   logic                      valid;
   logic                      ready;
   logic [edd_pkg::CHAN_W-1:0] red;
   logic [edd_pkg::CHAN_W-1:0] green;
   logic [edd_pkg::CHAN_W-1:0] blue;
   logic [edd_pkg::CHAN_W-1:0] alpha;
   logic                      frame_start;

   modport source (output valid, red, green, blue, alpha, frame_start, input ready);
   modport sink (input valid, red, green, blue, alpha, frame_start, output ready);
endinterface

interface edd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      white;
   logic [edd_pkg::CHAN_W-1:0] alpha_out;

   modport source (output valid, white, alpha_out, input ready);
   modport sink (input valid, white, alpha_out, output ready);
endinterface

### rtl/core/error_diffusion_dither_unit.sv
`timescale 1ns / 1ps
// Error diffusion dither unit: RGBA pixels in raster order to black or white pixels.
// Top level; depends on edd_pkg, edd_if, edd_front, edd_queue and edd_back.
//
// Usage:
// Pixels enter on req_chan, one transaction per pixel in raster order; a pixel with
// frame_start set begins a new frame at column 0 and clears all carried error.
// Each pixel yields exactly one transaction on rsp_chan with the white decision
// and the unchanged alpha. The user must write threshold, diffusion mode and image
// width through the csr_ port while no pixel is in flight; the block does not check.
// A pixel passes the queue slot, the stage-one register and the result register.
// Throughput: one pixel per clock unless stalled, set by the loop that carries the
// right-neighbour error from one pixel's decision to the next in the back end.
// The next-row and second-row error stores are 1024-entry memories with one write
// and one registered read per cycle; a per-frame fill mark replaces any clearing
// pass, so the block takes pixels from the first cycle after reset.
// Reset empties the pipeline, restores the register defaults and clears all errors.
// When the receiver stalls, the result is held, up to four pixels collect in the
// queue, and req_chan.ready then drops until results drain.

module error_diffusion_dither_unit (
   input  logic                              clock,
   input  logic                              reset,
   edd_req_if.sink                           req_chan,
   edd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [edd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [edd_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int INFLIGHT_MAX = edd_pkg::Q_DEPTH + 2;
   localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1);

   logic [edd_pkg::CHAN_W-1:0]       threshold_ff, threshold_in;
   logic                             mode_ff, mode_in;
   logic [edd_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [INFLIGHT_W-1:0]            inflight_ff, inflight_in;

   logic                  push;
   logic                  pop;
   edd_pkg::pix_type      push_item;
   edd_pkg::pix_type      head;
   edd_pkg::qstat_type    qstat;
   edd_pkg::bstat_type    bstat;
   logic                  req_fire;
   logic                  rsp_fire;

   always_comb begin
      threshold_in = threshold_ff;
      mode_in = mode_ff;
      width_in = width_ff;
      if (csr_we) begin
         case (csr_index)
            edd_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_wdata[edd_pkg::CHAN_W-1:0];
            end
            edd_pkg::CSR_MODE: begin
               mode_in = csr_wdata[0];
            end
            edd_pkg::CSR_WIDTH: begin
               width_in = csr_wdata[edd_pkg::WIDTH_REG_W-1:0];
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end

      req_fire = req_chan.valid && req_chan.ready;
      rsp_fire = rsp_chan.valid && rsp_chan.ready;
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= edd_pkg::THRESHOLD_RESET;
         mode_ff <= edd_pkg::MODE_FLOYD;
         width_ff <= edd_pkg::WIDTH_RESET;
         inflight_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
         mode_ff <= mode_in;
         width_ff <= width_in;
         inflight_ff <= inflight_in;
      end
   end

   edd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .image_width (width_ff),
      .qstat       (qstat),
      .push        (push),
      .push_item   (push_item)
   );

   edd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   edd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (qstat.empty),
      .pop            (pop),
      .threshold      (threshold_ff),
      .diffusion_mode (mode_ff),
      .rsp_chan       (rsp_chan),
      .bstat          (bstat)
   );

`ifndef SYNTH
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= INFLIGHT_W'(INFLIGHT_MAX))
      else $error("More pixels in flight than the pipeline can hold.");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> inflight_ff != '0)
      else $error("Result offered with no pixel in flight.");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      (qstat.empty && !bstat.s1_valid && !bstat.out_valid) |-> inflight_ff == '0)
      else $error("Pipeline empty while a pixel is still owed a result.");
`endif

endmodule

### rtl/core/edd_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks the raster column and computes Q8.8 luma.
// Depends on edd_pkg and edd_req_if; feeds edd_queue.

module edd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   edd_req_if.sink                               req_chan,
   input  logic [edd_pkg::WIDTH_REG_W-1:0]       image_width,
   input  edd_pkg::qstat_type                    qstat,
   output logic                                  push,
   output edd_pkg::pix_type                      push_item
);

   localparam int CMP_W = (edd_pkg::CNT_W > edd_pkg::WIDTH_REG_W) ?
                          edd_pkg::CNT_W : edd_pkg::WIDTH_REG_W;

   edd_pkg::col_type  column_ff;
   edd_pkg::col_type  column_in;
   edd_pkg::col_type  col;
   logic [CMP_W-1:0]  width_eff;
   logic              last;

   always_comb begin
      req_chan.ready = !qstat.full;
      push = req_chan.valid && req_chan.ready;

      width_eff = CMP_W'(image_width);
      if (width_eff == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_eff > CMP_W'(edd_pkg::WIDTH_MAX)) begin
         width_eff = CMP_W'(edd_pkg::WIDTH_MAX);
      end

      col = req_chan.frame_start ? '0 : column_ff;
      last = (CMP_W'(col) + CMP_W'(1)) >= width_eff;

      column_in = column_ff;
      if (push) begin
         column_in = last ? '0 : edd_pkg::col_type'(col + 1'b1);
      end

      push_item.col = col;
      push_item.last = last;
      push_item.frame_start = req_chan.frame_start;
      push_item.alpha = req_chan.alpha;
      push_item.luma = edd_pkg::luma_type'(edd_pkg::COEF_R) * edd_pkg::luma_type'(req_chan.red)
                     + edd_pkg::luma_type'(edd_pkg::COEF_G) * edd_pkg::luma_type'(req_chan.green)
                     + edd_pkg::luma_type'(edd_pkg::COEF_B) * edd_pkg::luma_type'(req_chan.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else begin
         column_ff <= column_in;
      end
   end

endmodule

### rtl/core/edd_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of classified pixels between front and back end.
// Depends on edd_pkg.

module edd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  edd_pkg::pix_type     push_item,
   input  logic                 pop,
   output edd_pkg::pix_type     head,
   output edd_pkg::qstat_type   qstat
);

   edd_pkg::pix_type              slot_ff [edd_pkg::Q_DEPTH];
   logic [edd_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [edd_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [edd_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [edd_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [edd_pkg::QCNT_W-1:0]    count_ff;
   logic [edd_pkg::QCNT_W-1:0]    count_in;

   always_comb begin
      head = slot_ff[rd_ptr_ff];
      qstat.empty = (count_ff == '0);
      qstat.full = (count_ff == edd_pkg::QCNT_W'(edd_pkg::Q_DEPTH));

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/edd_back.sv
`timescale 1ns / 1ps
// Back end: row error stores, threshold decision, error spreading and result register.
// Depends on edd_pkg and edd_rsp_if; drains edd_queue.

module edd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  edd_pkg::pix_type                head,
   input  logic                            q_empty,
   output logic                            pop,
   input  logic [edd_pkg::CHAN_W-1:0]      threshold,
   input  logic                            diffusion_mode,
   edd_rsp_if.source                       rsp_chan,
   output edd_pkg::bstat_type              bstat
);

   // Error store entries count as written only below the per-frame fill mark.
   edd_pkg::err_type   nre_ram_ff [edd_pkg::WIDTH_MAX];
   edd_pkg::err_type   sre_ram_ff [edd_pkg::WIDTH_MAX];
   edd_pkg::err_type   nre_rd_ff;
   edd_pkg::err_type   sre_rd_ff;
   edd_pkg::err_type   nre_byp_dat_ff;
   edd_pkg::err_type   sre_byp_dat_ff;
   logic               nre_byp_ff;
   logic               sre_byp_ff;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   edd_pkg::pix_type   s1_pix_ff;

   edd_pkg::err_type   cr1_ff, cr1_in;
   edd_pkg::err_type   cr2_ff, cr2_in;
   edd_pkg::err_type   brp_ff, brp_in;
   logic               pend_valid_ff, pend_valid_in;
   edd_pkg::col_type   pend_addr_ff, pend_addr_in;
   edd_pkg::err_type   pend_val_ff, pend_val_in;
   logic               pend_final_ff, pend_final_in;
   edd_pkg::cnt_type   fill_ff, fill_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_white_ff, out_white_in;
   logic [edd_pkg::CHAN_W-1:0] out_alpha_ff, out_alpha_in;

   logic               advance;
   logic               fs;
   logic               rd_valid;
   logic               nre_we;
   edd_pkg::col_type   nre_waddr;
   edd_pkg::err_type   nre_wdata;
   edd_pkg::err_type   sre_wdata;
   edd_pkg::err_type   nre_c;
   edd_pkg::err_type   sec_c;
   edd_pkg::err_type   cr1_u;
   edd_pkg::err_type   cr2_u;
   edd_pkg::err_type   brp_u;
   edd_pkg::err_type   carried;
   edd_pkg::err_type   pend_new;
   edd_pkg::wide_type  sum;
   edd_pkg::wide_type  delta;
   edd_pkg::wide_type  s_r1, s_r2, s_left, s_mid, s_right, s_down2, s_at;
   logic               white;
   edd_pkg::cnt_type   fill_base;
   edd_pkg::cnt_type   col_next;

   always_comb begin
      advance = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
      pop = !q_empty && (!s1_valid_ff || advance);
      s1_valid_in = pop ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

      fs = s1_pix_ff.frame_start;
      fill_base = fs ? '0 : fill_ff;
      rd_valid = edd_pkg::cnt_type'(s1_pix_ff.col) < fill_base;

      if (!rd_valid) begin
         nre_c = '0;
         sec_c = '0;
      end else begin
         if (pend_valid_ff && (pend_addr_ff == s1_pix_ff.col)) begin
            nre_c = pend_val_ff;
         end else begin
            nre_c = nre_byp_ff ? nre_byp_dat_ff : nre_rd_ff;
         end
         sec_c = sre_byp_ff ? sre_byp_dat_ff : sre_rd_ff;
      end

      cr1_u = fs ? '0 : cr1_ff;
      cr2_u = fs ? '0 : cr2_ff;
      brp_u = fs ? '0 : brp_ff;

      carried = edd_pkg::sat_err(edd_pkg::wide_type'(cr1_u) + edd_pkg::wide_type'(nre_c));
      sum = edd_pkg::wide_type'({1'b0, s1_pix_ff.luma}) + edd_pkg::wide_type'(carried);
      white = sum > edd_pkg::wide_type'({1'b0, threshold, 8'd0});
      delta = white ? sum - edd_pkg::wide_type'(edd_pkg::FULL_Q88) : sum;

      s_at = delta >>> edd_pkg::SHIFT_AT;
      if (diffusion_mode == edd_pkg::MODE_ATKINSON) begin
         s_r1 = s_at;
         s_r2 = s_at;
         s_left = s_at;
         s_mid = s_at;
         s_right = s_at;
         s_down2 = s_at;
      end else begin
         s_r1 = (delta * edd_pkg::wide_type'(edd_pkg::W_RIGHT)) >>> edd_pkg::SHIFT_FS;
         s_r2 = '0;
         s_left = (delta * edd_pkg::wide_type'(edd_pkg::W_LEFT)) >>> edd_pkg::SHIFT_FS;
         s_mid = (delta * edd_pkg::wide_type'(edd_pkg::W_MID)) >>> edd_pkg::SHIFT_FS;
         s_right = delta >>> edd_pkg::SHIFT_FS;
         s_down2 = '0;
      end

      pend_new = edd_pkg::sat_err(edd_pkg::wide_type'(brp_u) + s_mid
                                  + edd_pkg::wide_type'(sec_c));

      // The held prior-column entry takes its below-left share now unless it was last.
      nre_we = advance && pend_valid_ff && !fs;
      nre_waddr = pend_addr_ff;
      nre_wdata = pend_final_ff ? pend_val_ff :
                  edd_pkg::sat_err(edd_pkg::wide_type'(pend_val_ff) + s_left);
      sre_wdata = edd_pkg::sat_err(s_down2);

      col_next = edd_pkg::cnt_type'(s1_pix_ff.col) + 1'b1;

      cr1_in = cr1_ff;
      cr2_in = cr2_ff;
      brp_in = brp_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in = pend_addr_ff;
      pend_val_in = pend_val_ff;
      pend_final_in = pend_final_ff;
      fill_in = fill_ff;
      if (advance) begin
         if (s1_pix_ff.last) begin
            cr1_in = '0;
            cr2_in = '0;
            brp_in = '0;
         end else begin
            cr1_in = edd_pkg::sat_err(edd_pkg::wide_type'(cr2_u) + s_r1);
            cr2_in = edd_pkg::sat_err(s_r2);
            brp_in = edd_pkg::sat_err(s_right);
         end
         pend_valid_in = 1'b1;
         pend_addr_in = s1_pix_ff.col;
         pend_val_in = pend_new;
         pend_final_in = s1_pix_ff.last;
         fill_in = (col_next > fill_base) ? col_next : fill_base;
      end

      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_white_in = advance ? white : out_white_ff;
      out_alpha_in = advance ? s1_pix_ff.alpha : out_alpha_ff;

      rsp_chan.valid = out_valid_ff;
      rsp_chan.white = out_white_ff;
      rsp_chan.alpha_out = out_alpha_ff;

      bstat.s1_valid = s1_valid_ff;
      bstat.out_valid = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (nre_we) begin
         nre_ram_ff[nre_waddr] <= nre_wdata;
      end
      if (advance) begin
         sre_ram_ff[s1_pix_ff.col] <= sre_wdata;
      end
      if (pop) begin
         nre_rd_ff <= nre_ram_ff[head.col];
         sre_rd_ff <= sre_ram_ff[head.col];
         nre_byp_ff <= nre_we && (nre_waddr == head.col);
         nre_byp_dat_ff <= nre_wdata;
         sre_byp_ff <= advance && (s1_pix_ff.col == head.col);
         sre_byp_dat_ff <= sre_wdata;
         s1_pix_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      out_white_ff <= out_white_in;
      out_alpha_ff <= out_alpha_in;
      pend_addr_ff <= pend_addr_in;
      pend_val_ff <= pend_val_in;
      pend_final_ff <= pend_final_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         fill_ff <= '0;
         cr1_ff <= '0;
         cr2_ff <= '0;
         brp_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         fill_ff <= fill_in;
         cr1_ff <= cr1_in;
         cr2_ff <= cr2_in;
         brp_ff <= brp_in;
      end
   end

endmodule

### tb/edd_dither_checker.sv
`timescale 1ns / 1ps
// Checker for the error diffusion dither unit. It predicts the black or white decision
// and alpha of each accepted pixel and compares every response transaction in order.
// Depends on edd_pkg and on the edd_req_if and edd_rsp_if interfaces.

module edd_dither_checker (
   input  logic                          clock,
   input  logic                          reset,
   edd_req_if                            req_chan,
   edd_rsp_if                            rsp_chan,
   input  logic                          csr_we,
   input  logic [edd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [edd_pkg::CSR_W-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            awaiting_count
);

   localparam int LUMA_R      = 77;
   localparam int LUMA_G      = 150;
   localparam int LUMA_B      = 29;
   localparam int WHITE_LEVEL = 255 * 256;
   localparam int ERR_HI      = 524287;
   localparam int ERR_LO      = -524288;

   typedef struct packed {
      logic                       white;
      logic [edd_pkg::CHAN_W-1:0] alpha;
   } bw_pixel_type;

   bw_pixel_type      predicted_bw[$];
   edd_pkg::err_type  row_below_err [edd_pkg::WIDTH_MAX];
   edd_pkg::err_type  row_after_err [edd_pkg::WIDTH_MAX];
   edd_pkg::err_type  right_one_err;
   edd_pkg::err_type  right_two_err;
   edd_pkg::err_type  below_right_err;
   int         column_now;
   logic [7:0] threshold_q;
   logic       mode_q;
   logic [10:0] width_q;
   int         results_seen;

   function automatic int clamp_err(input int v);
      if (v > ERR_HI) begin
         return ERR_HI;
      end
      if (v < ERR_LO) begin
         return ERR_LO;
      end
      return v;
   endfunction

   function automatic void clear_errors();
      for (int i = 0; i < edd_pkg::WIDTH_MAX; i++) begin
         row_below_err[i] = '0;
         row_after_err[i] = '0;
      end
      right_one_err   = '0;
      right_two_err   = '0;
      below_right_err = '0;
      column_now      = 0;
   endfunction

   function automatic bw_pixel_type dither_pixel(input logic [7:0] red,
                                                 input logic [7:0] green,
                                                 input logic [7:0] blue,
                                                 input logic [7:0] alpha,
                                                 input logic frame_start);
      int           span;
      int           col;
      int           luma;
      int           carried;
      int           total;
      int           delta;
      int           to_right;
      int           to_right2;
      int           to_left;
      int           to_mid;
      int           to_below_right;
      int           to_two_down;
      logic         row_end;
      bw_pixel_type res;
      if (frame_start) begin
         clear_errors();
      end
      span = int'(width_q);
      if (span == 0) begin
         span = 1;
      end
      if (span > edd_pkg::WIDTH_MAX) begin
         span = edd_pkg::WIDTH_MAX;
      end
      col = (column_now >= edd_pkg::WIDTH_MAX) ? edd_pkg::WIDTH_MAX - 1 : column_now;
      row_end = (col + 1 >= span);

      luma = LUMA_R * int'(red) + LUMA_G * int'(green) + LUMA_B * int'(blue);
      carried = clamp_err(int'(right_one_err) + int'(row_below_err[col]));
      total = luma + carried;
      res.white = (total > int'(threshold_q) * 256);
      delta = res.white ? total - WHITE_LEVEL : total;

      if (mode_q == edd_pkg::MODE_FLOYD) begin
         to_right       = (delta * 7) >>> 4;
         to_right2      = 0;
         to_left        = (delta * 3) >>> 4;
         to_mid         = (delta * 5) >>> 4;
         to_below_right = delta >>> 4;
         to_two_down    = 0;
      end else begin
         to_right       = delta >>> 3;
         to_right2      = to_right;
         to_left        = to_right;
         to_mid         = to_right;
         to_below_right = to_right;
         to_two_down    = to_right;
      end

      row_below_err[col] = edd_pkg::err_type'(clamp_err(int'(below_right_err) + to_mid
                                                        + int'(row_after_err[col])));
      row_after_err[col] = edd_pkg::err_type'(clamp_err(to_two_down));
      if (col > 0) begin
         row_below_err[col - 1] =
            edd_pkg::err_type'(clamp_err(int'(row_below_err[col - 1]) + to_left));
      end

      if (row_end) begin
         below_right_err = '0;
         right_one_err   = '0;
         right_two_err   = '0;
         column_now      = 0;
      end else begin
         below_right_err = edd_pkg::err_type'(clamp_err(to_below_right));
         right_one_err   = edd_pkg::err_type'(clamp_err(int'(right_two_err) + to_right));
         right_two_err   = edd_pkg::err_type'(clamp_err(to_right2));
         column_now      = col + 1;
      end

      res.alpha = alpha;
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("%0t: dither mismatch, %s", $time, what);
   endtask

   always @(posedge clock) begin : monitor
      bw_pixel_type want;
      if (reset) begin
         threshold_q = 8'd128;
         mode_q      = edd_pkg::MODE_FLOYD;
         width_q     = 11'd1024;
         clear_errors();
         predicted_bw.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_bw.size() == 0) begin
               flag_mismatch($sformatf("response %0d arrived with no pixel outstanding",
                                       results_seen));
            end else begin
               want = predicted_bw.pop_front();
               if (rsp_chan.white !== want.white) begin
                  flag_mismatch($sformatf("response %0d white %b, expected %b",
                                          results_seen, rsp_chan.white, want.white));
               end
               if (rsp_chan.alpha_out !== want.alpha) begin
                  flag_mismatch($sformatf("response %0d alpha_out %0d, expected %0d",
                                          results_seen, rsp_chan.alpha_out, want.alpha));
               end
            end
            results_seen++;
         end
         if (csr_we) begin
            case (csr_index)
               edd_pkg::CSR_THRESHOLD: begin
                  threshold_q = csr_wdata[7:0];
               end
               edd_pkg::CSR_MODE: begin
                  mode_q = csr_wdata[0];
               end
               edd_pkg::CSR_WIDTH: begin
                  width_q = csr_wdata[10:0];
               end
               default: begin
               end
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            predicted_bw.push_back(dither_pixel(req_chan.red, req_chan.green, req_chan.blue,
                                                req_chan.alpha, req_chan.frame_start));
         end
      end
      awaiting_count <= predicted_bw.size();
   end

endmodule

### tb/tb_error_diffusion_dither_unit.sv
`timescale 1ns / 1ps
// Top of the error diffusion dither testbench: clock, reset, pixel stimulus, register
// settings and response back-pressure. Depends on edd_pkg, the edd interfaces, the
// dither unit and edd_dither_checker, which does all prediction and comparison.

module tb_error_diffusion_dither_unit;

   localparam int ITEM_TARGET  = 950;
   localparam int CALM_TAIL    = 120;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 250;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [edd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [edd_pkg::CSR_W-1:0]     csr_wdata;
   logic                          calm;
   logic                          long_hold_req;
   int                            mismatch_count;
   int                            awaiting_count;
   int                            cycle_count;
   int                            pixels_sent;

   edd_req_if req_chan ();
   edd_rsp_if rsp_chan ();

   error_diffusion_dither_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   edd_dither_checker dither_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] alpha,
                             input logic frame_start);
      req_chan.valid       <= 1'b1;
      req_chan.red         <= red;
      req_chan.green       <= green;
      req_chan.blue        <= blue;
      req_chan.alpha       <= alpha;
      req_chan.frame_start <= frame_start;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      pixels_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_random_pixel(input logic frame_start);
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      red   = 8'($urandom);
      green = 8'($urandom);
      blue  = 8'($urandom);
      case ($urandom_range(0, 7))
         0: begin
            red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         1: begin
            green = red;
            blue  = red;
         end
         default: begin
         end
      endcase
      send_pixel(red, green, blue, 8'($urandom), frame_start);
   endtask

   task automatic write_csr(input logic [edd_pkg::CSR_IDX_W-1:0] index,
                            input logic [edd_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic settle_and_configure(input logic [7:0] threshold, input logic mode,
                                       input logic [10:0] width);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(edd_pkg::CSR_THRESHOLD, edd_pkg::CSR_W'(threshold));
      write_csr(edd_pkg::CSR_MODE, edd_pkg::CSR_W'(mode));
      write_csr(edd_pkg::CSR_WIDTH, width);
      csr_we <= 1'b0;
   endtask

   initial begin : response_side
      int   run_len;
      logic hold_done;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_chan.ready <= 1'b1;
         run_len = $urandom_range(1, 40);
         repeat (run_len) @(posedge clock);
         if (!calm && $urandom_range(0, 2) != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  thr;
      logic        mode;
      logic [10:0] width;
      int          run_len;
      int          phase;
      calm                 = 1'b0;
      long_hold_req        = 1'b0;
      req_chan.valid       <= 1'b0;
      req_chan.red         <= '0;
      req_chan.green       <= '0;
      req_chan.blue        <= '0;
      req_chan.alpha       <= '0;
      req_chan.frame_start <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      reset                <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 8'h5A, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 8'hA5, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 8'd1, 1'b0);

      settle_and_configure(8'd0, edd_pkg::MODE_ATKINSON, 11'd3);
      send_pixel(8'd0, 8'd0, 8'd0, 8'h11, 1'b1);
      for (int k = 0; k < 6; k++) begin
         send_random_pixel(1'b0);
      end

      settle_and_configure(8'd255, edd_pkg::MODE_FLOYD, 11'd1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'h7F, 1'b1);
      send_pixel(8'd200, 8'd220, 8'd240, 8'h80, 1'b0);

      settle_and_configure(8'd100, edd_pkg::MODE_ATKINSON, 11'd0);
      send_pixel(8'd90, 8'd120, 8'd30, 8'h33, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 8'hCC, 1'b0);

      settle_and_configure(8'd64, edd_pkg::MODE_ATKINSON, 11'd2047);
      send_pixel(8'd60, 8'd70, 8'd80, 8'h0F, 1'b1);
      send_pixel(8'd10, 8'd20, 8'd30, 8'hF0, 1'b0);

      settle_and_configure(8'd128, edd_pkg::MODE_FLOYD, 11'd5);
      send_pixel(8'd100, 8'd100, 8'd100, 8'h01, 1'b1);
      send_random_pixel(1'b0);
      send_random_pixel(1'b0);
      send_random_pixel(1'b0);
      settle_and_configure(8'd128, edd_pkg::MODE_FLOYD, 11'd2);
      send_random_pixel(1'b0);
      send_random_pixel(1'b0);
      send_random_pixel(1'b0);

      phase = 0;
      while (pixels_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0: thr = 8'd0;
            1: thr = 8'd255;
            default: thr = 8'($urandom);
         endcase
         mode = $urandom_range(0, 1) ? edd_pkg::MODE_ATKINSON : edd_pkg::MODE_FLOYD;
         case ($urandom_range(0, 11))
            0: width = 11'd1;
            1: width = 11'd2;
            2: width = 11'd1024;
            3: width = 11'($urandom_range(1025, 2047));
            4: width = 11'd0;
            default: width = 11'($urandom_range(3, 24));
         endcase
         run_len = (phase == 1) ? 160 : $urandom_range(30, 110);
         settle_and_configure(thr, mode, width);
         if (phase == 1) begin
            long_hold_req = 1'b1;
         end
         for (int k = 0; k < run_len && pixels_sent < ITEM_TARGET; k++) begin
            calm = (ITEM_TARGET - pixels_sent <= CALM_TAIL);
            send_random_pixel((k == 0 && $urandom_range(0, 1) == 1)
                              || $urandom_range(0, 59) == 0);
         end
         phase++;
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
